// ===== rtl/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and codes of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned ID_W     = 2;
    localparam int unsigned MASK_W   = 4;
    localparam int unsigned ACT_W    = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned PERIOD_N = 4;

    typedef logic [CMD_W-1:0]      t_cmd;
    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [ID_W-1:0]       t_slot_id;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // request commands
    localparam t_cmd CMD_PROCESS = 2'd0;
    localparam t_cmd CMD_ENABLE  = 2'd1;
    localparam t_cmd CMD_DISABLE = 2'd2;
    localparam t_cmd CMD_INIT    = 2'd3;

    // configuration register indexes
    localparam t_cfg_idx REG_ACTIVE_COUNT = 3'd0;
    localparam t_cfg_idx REG_HANDLER_MASK = 3'd1;
    localparam t_cfg_idx REG_START_MASK   = 3'd2;
    localparam t_cfg_idx REG_PERIOD0      = 3'd3;
    localparam t_cfg_idx REG_PERIOD1      = 3'd4;
    localparam t_cfg_idx REG_PERIOD2      = 3'd5;
    localparam t_cfg_idx REG_PERIOD3      = 3'd6;

    // operands handed to the shared elapsed-time compare unit
    typedef struct packed {
        t_time now;
        t_time stamp;
        t_time period;
    } t_due_req;

endpackage

// ===== rtl/ptts_if.sv =====
// ----------------------------------------------------------------------------
// ptts_in_if / ptts_out_if
// Valid/ready channels of the scheduler: command requests in, fire results out.
// ----------------------------------------------------------------------------
interface ptts_in_if;
    logic                 valid;
    logic                 ready;
    ptts_pkg::t_cmd       cmd;
    ptts_pkg::t_time      now_ms;
    ptts_pkg::t_slot_id   slot_id;

    modport source (output valid, cmd, now_ms, slot_id, input ready);
    modport sink   (input valid, cmd, now_ms, slot_id, output ready);
endinterface

interface ptts_out_if;
    logic                 valid;
    logic                 ready;
    ptts_pkg::t_slot_id   fired_slot;
    logic                 last_fire;

    modport source (output valid, fired_slot, last_fire, input ready);
    modport sink   (input valid, fired_slot, last_fire, output ready);
endinterface

// ===== rtl/ptts_due_unit.sv =====
// ----------------------------------------------------------------------------
// ptts_due_unit
// Shared compare unit: wrapping elapsed time against a slot period.
// ----------------------------------------------------------------------------
module ptts_due_unit (
    input  ptts_pkg::t_due_req i_req,
    output logic               o_due
);
    import ptts_pkg::*;

    t_time elapsed;

    // modulo 2^32 subtraction handles timer wrap
    assign elapsed = i_req.now - i_req.stamp;
    assign o_due   = (elapsed >= i_req.period);

endmodule

// ===== rtl/periodic_task_tick_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Periodic task slot table with a one-slot-per-cycle process scan.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries command requests (process, enable, disable, init) with the
//   current millisecond time. o_rsp carries one fire result per due slot of a
//   process request, in slot order, last_fire marking the final one.
//   Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Throughput:
//   Enable, disable and init complete in the accept cycle; i_req.ready stays
//   high, so one such request per cycle.
//   A process request with n live slots scans one slot per cycle through the
//   shared compare unit, then emits its fire results one per cycle while
//   o_rsp.ready does not stall the output register.
// Reset:
//   Synchronous, active low. Clears configuration registers, stamps, running
//   flags, the sequencer state and the output valid flag.
// Stall:
//   A single output register holds a result while o_rsp.ready is low; the
//   emit phase waits, and i_req.ready stays low until the last result of the
//   process request is loaded into that register.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ptts_in_if.sink               i_req,
    ptts_out_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  ptts_pkg::t_cfg_idx    i_cfg_idx,
    input  ptts_pkg::t_cfg_data   i_cfg_data
);
    import ptts_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // configuration
    logic [ACT_W-1:0]  r_active_count;
    logic [MASK_W-1:0] r_handler_mask;
    logic [MASK_W-1:0] r_start_mask;
    t_time             r_period [PERIOD_N];

    // slot table
    t_time                 r_stamp [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_running;

    // sequencer
    logic [1:0]            r_state;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_live;
    t_time                 r_now;
    logic [SLOT_COUNT-1:0] r_due;

    // output register
    logic     r_out_valid;
    t_slot_id r_out_slot;
    logic     r_out_last;

    logic [CNT_W-1:0]      live_n;
    logic                  in_acc;
    logic                  id_ok;
    logic [SLOT_W-1:0]     id_sel;
    logic [SLOT_W-1:0]     scan_sel;
    logic [ID_W-1:0]       scan_id;
    logic                  scan_act;
    logic                  scan_fire;
    t_due_req              due_req;
    logic                  due_hit;
    logic                  out_load;
    logic [SLOT_W-1:0]     low_sel;
    logic [SLOT_COUNT-1:0] due_rest;

    assign live_n = (r_active_count > ACT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT)
                                                           : CNT_W'(r_active_count);

    assign i_req.ready = (r_state == ST_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign id_ok       = (ACT_W'(i_req.slot_id) < ACT_W'(live_n));
    assign id_sel      = SLOT_W'(i_req.slot_id);

    // scan operands
    assign scan_sel  = SLOT_W'(r_idx);
    assign scan_id   = ID_W'(r_idx);
    assign scan_act  = (r_state == ST_SCAN) && (r_idx < r_live);
    assign due_req.now    = r_now;
    assign due_req.stamp  = r_stamp[scan_sel];
    assign due_req.period = r_period[scan_id];

    ptts_due_unit u_due (
        .i_req (due_req),
        .o_due (due_hit)
    );

    assign scan_fire = scan_act && r_running[scan_sel] && r_handler_mask[scan_id] && due_hit;

    // lowest pending fire
    always_comb begin
        low_sel = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_due[i]) begin
                low_sel = SLOT_W'(i);
            end
        end
    end
    assign due_rest = r_due & (r_due - SLOT_COUNT'(1));
    assign out_load = (r_state == ST_EMIT) && (!r_out_valid || o_rsp.ready);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= '0;
            r_handler_mask <= '0;
            r_start_mask   <= '0;
            for (int i = 0; i < PERIOD_N; i++) begin
                r_period[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ACTIVE_COUNT: r_active_count <= i_cfg_data[ACT_W-1:0];
                REG_HANDLER_MASK: r_handler_mask <= i_cfg_data[MASK_W-1:0];
                REG_START_MASK:   r_start_mask   <= i_cfg_data[MASK_W-1:0];
                REG_PERIOD0:      r_period[0]    <= i_cfg_data;
                REG_PERIOD1:      r_period[1]    <= i_cfg_data;
                REG_PERIOD2:      r_period[2]    <= i_cfg_data;
                REG_PERIOD3:      r_period[3]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // slot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_stamp[i] <= '0;
            end
        end else if (in_acc) begin
            unique case (i_req.cmd)
                CMD_INIT: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        r_stamp[i]   <= i_req.now_ms;
                        r_running[i] <= r_start_mask[i];
                    end
                end
                CMD_ENABLE: begin
                    if (id_ok) begin
                        r_running[id_sel] <= 1'b1;
                        r_stamp[id_sel]   <= i_req.now_ms;
                    end
                end
                CMD_DISABLE: begin
                    if (id_ok) begin
                        r_running[id_sel] <= 1'b0;
                    end
                end
                CMD_PROCESS: ;
                default: ;
            endcase
        end else if (scan_fire) begin
            r_stamp[scan_sel] <= r_now;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_live  <= '0;
            r_due   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (i_req.cmd == CMD_PROCESS)) begin
                        r_state <= ST_SCAN;
                        r_idx   <= '0;
                        r_live  <= live_n;
                        r_due   <= '0;
                    end
                end
                ST_SCAN: begin
                    if (scan_act) begin
                        r_idx <= r_idx + CNT_W'(1);
                        if (scan_fire) begin
                            r_due[scan_sel] <= 1'b1;
                        end
                    end else begin
                        r_state <= (r_due != '0) ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_load) begin
                        r_due <= due_rest;
                        if (due_rest == '0) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_req.cmd == CMD_PROCESS)) begin
            r_now <= i_req.now_ms;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_slot <= ID_W'(low_sel);
            r_out_last <= (due_rest == '0);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.fired_slot = r_out_slot;
    assign o_rsp.last_fire  = r_out_last;

endmodule

// ===== rtl/ptts_checker.sv =====
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
module ptts_checker #(
    parameter int SLOT_COUNT = 4
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input ptts_pkg::t_cmd     i_in_cmd,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input ptts_pkg::t_slot_id i_out_slot,
    input logic               i_out_last
);
    import ptts_pkg::*;

    // output register comes out of reset empty
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_slot)
                                        && $stable(i_out_last))
        else $error("stalled result changed");

    // more results of the same tick pending: no new request taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |-> !i_in_ready)
        else $error("request taken while tick results pending");

    // non-process commands finish at once
    a_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd != CMD_PROCESS) |=> i_in_ready)
        else $error("busy after table command");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_out_slot) < SLOT_COUNT))
        else $error("fired slot out of range");

endmodule

bind periodic_task_tick_scheduler ptts_checker #(.SLOT_COUNT(SLOT_COUNT)) u_ptts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_cmd    (i_req.cmd),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_slot  (o_rsp.fired_slot),
    .i_out_last  (o_rsp.last_fire)
);
